// ===== hdl/ijts_pkg.sv =====
package ijts_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PE32_MODE   = 3'd0,
        CFG_SECTION_RVA = 3'd1,
        CFG_MAPPED_BASE = 3'd2,
        CFG_IMAGE_SIZE  = 3'd3,
        CFG_MAX_TARGETS = 3'd4
    } t_cfg_idx;

    localparam logic [7:0] OPC_ESC    = 8'hff;
    localparam logic [7:0] MODRM_JMP  = 8'h25;
    localparam logic [7:0] MODRM_CALL = 8'h15;
    localparam logic [2:0] WIN_LEN    = 3'd6;
    localparam logic [2:0] HIST_LEN   = 3'd5;
    localparam logic [3:0] ESIZE_32   = 4'd4;
    localparam logic [3:0] ESIZE_64   = 4'd8;
    localparam logic [5:0] MAX_T_RST  = 6'd32;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CALC  = 6'b000010,
        S_CHECK = 6'b000100,
        S_DEDUP = 6'b001000,
        S_WRAP  = 6'b010000,
        S_MIN   = 6'b100000
    } t_state;

    typedef struct packed {
        logic load;
        logic calc;
        logic scan_init;
        logic scan_step;
        logic insert;
        logic sort_init;
        logic emit;
        logic emit_empty;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic keep;
        logic scan_done;
        logic hit;
        logic last_one;
        logic count_zero;
        logic last_item;
    } t_stat;

endpackage

// ===== hdl/ijts_ram.sv =====
module ijts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ijts_ctrl.sv =====
module ijts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    output ijts_pkg::t_cmd o_cmd,
    input  ijts_pkg::t_stat i_stat
);
    import ijts_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.keep) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_DEDUP;
                end else begin
                    n_state = S_WRAP;
                end
            end
            S_DEDUP: begin
                if (i_stat.scan_done) begin
                    o_cmd.insert = !i_stat.hit;
                    n_state      = S_WRAP;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_WRAP: begin
                if (!i_stat.last_item) begin
                    n_state = S_IDLE;
                end else if (i_stat.count_zero) begin
                    o_cmd.emit_empty = 1'b1;
                    o_cmd.clear      = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.sort_init = 1'b1;
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_MIN;
                end
            end
            S_MIN: begin
                if (i_stat.scan_done) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last_one) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== hdl/ijts_dp.sv =====
module ijts_dp #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ijts_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ijts_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [7:0]                          i_code_byte,
    input  logic                                i_last_byte,
    input  ijts_pkg::t_cmd                      i_cmd,
    output ijts_pkg::t_stat                     o_stat,
    output logic                                o_strobe,
    output logic [31:0]                         o_target_value,
    output logic                                o_entry_valid,
    output logic                                o_final_entry,
    output logic [5:0]                          o_entry_total
);
    import ijts_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = (CW > 6) ? CW : 6;

    // configuration
    logic        r_pe32;
    logic [31:0] r_rva;
    logic [31:0] r_base;
    logic [31:0] r_img;
    logic [5:0]  r_max_t;

    // byte window
    logic [7:0]  r_hist [5];
    logic [2:0]  r_fill;
    logic [31:0] r_pos;
    logic        r_match;
    logic [31:0] r_raw;
    logic [31:0] r_k;
    logic        r_last;
    logic [34:0] r_sum;

    // table scan
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_ptr;
    logic          r_pend;
    logic          r_hit;
    logic [31:0]   r_best;
    logic          r_best_v;
    logic [31:0]   r_prev;
    logic          r_have_prev;
    logic [CW-1:0] r_out_idx;

    // result beat
    logic        r_strobe;
    logic [31:0] r_tv;
    logic        r_ev;
    logic        r_fe;
    logic [5:0]  r_tot;

    logic        win_match;
    logic [34:0] n_sum;
    logic        in_range;
    logic        size_ok;
    logic [3:0]  esize;
    logic        room;
    logic        ram_we;
    logic [31:0] ram_rdata;
    logic        elig;
    logic        better;
    logic [CW-1:0] out_next;

    assign win_match = (r_fill >= HIST_LEN) && (r_hist[0] == OPC_ESC) &&
                       ((r_hist[1] == MODRM_JMP) || (r_pe32 && (r_hist[1] == MODRM_CALL)));

    always_comb begin
        if (r_pe32) begin
            n_sum = {3'b000, r_raw - r_base};
        end else begin
            n_sum = {3'b000, r_rva} + {3'b000, r_k} + {32'd0, WIN_LEN} +
                    {{3{r_raw[31]}}, r_raw};
        end
    end

    assign esize    = r_pe32 ? ESIZE_32 : ESIZE_64;
    assign in_range = r_pe32 || (r_sum[34:32] == 3'b000);
    assign size_ok  = ({1'b0, r_sum[31:0]} + {29'd0, esize}) <= {1'b0, r_img};

    assign room   = (LW'(r_count) < LW'(r_max_t)) && (LW'(r_count) < LW'(TABLE_DEPTH));
    assign ram_we = i_cmd.insert && room;

    assign elig     = !r_have_prev || (ram_rdata > r_prev);
    assign better   = !r_best_v || (ram_rdata < r_best);
    assign out_next = r_out_idx + CW'(1);

    assign o_stat.keep       = r_match && in_range && size_ok;
    assign o_stat.scan_done  = (r_ptr == r_count) && !r_pend;
    assign o_stat.hit        = r_hit;
    assign o_stat.last_one   = (out_next == r_count);
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.last_item  = r_last;

    ijts_ram #(
        .WIDTH(32),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_sum[31:0]),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pe32      <= 1'b0;
            r_rva       <= '0;
            r_base      <= '0;
            r_img       <= '0;
            r_max_t     <= MAX_T_RST;
            r_fill      <= '0;
            r_pos       <= '0;
            r_count     <= '0;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_strobe    <= 1'b0;
            r_have_prev <= 1'b0;
            r_out_idx   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_PE32_MODE:   r_pe32  <= i_cfg_data[0];
                    CFG_SECTION_RVA: r_rva   <= i_cfg_data;
                    CFG_MAPPED_BASE: r_base  <= i_cfg_data;
                    CFG_IMAGE_SIZE:  r_img   <= i_cfg_data;
                    CFG_MAX_TARGETS: r_max_t <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_pos <= r_pos + 32'd1;
                if (r_fill < HIST_LEN) begin
                    r_fill <= r_fill + 3'd1;
                end
            end
            if (i_cmd.scan_init) begin
                r_ptr  <= '0;
                r_pend <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (r_ptr != r_count) begin
                    r_ptr  <= r_ptr + CW'(1);
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
            end
            if (ram_we) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.sort_init) begin
                r_have_prev <= 1'b0;
                r_out_idx   <= '0;
            end else if (i_cmd.emit) begin
                r_have_prev <= 1'b1;
                r_out_idx   <= out_next;
            end
            r_strobe <= i_cmd.emit || i_cmd.emit_empty;
            if (i_cmd.clear) begin
                r_fill  <= '0;
                r_pos   <= '0;
                r_count <= '0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_match <= win_match;
            r_raw   <= {i_code_byte, r_hist[4], r_hist[3], r_hist[2]};
            r_k     <= r_pos - {29'd0, HIST_LEN};
            r_last  <= i_last_byte;
            for (int i = 0; i < 4; i++) begin
                r_hist[i] <= r_hist[i+1];
            end
            r_hist[4] <= i_code_byte;
        end
        if (i_cmd.calc) begin
            r_sum <= n_sum;
        end
        if (i_cmd.scan_init) begin
            r_hit    <= 1'b0;
            r_best_v <= 1'b0;
        end else if (r_pend) begin
            if (ram_rdata == r_sum[31:0]) begin
                r_hit <= 1'b1;
            end
            if (elig && better) begin
                r_best   <= ram_rdata;
                r_best_v <= 1'b1;
            end
        end
        if (i_cmd.emit) begin
            r_prev <= r_best;
            r_tv   <= r_best;
            r_ev   <= 1'b1;
            r_fe   <= o_stat.last_one;
            r_tot  <= 6'(r_count);
        end else if (i_cmd.emit_empty) begin
            r_tv  <= '0;
            r_ev  <= 1'b0;
            r_fe  <= 1'b1;
            r_tot <= '0;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_target_value = r_tv;
    assign o_entry_valid  = r_ev;
    assign o_final_entry  = r_fe;
    assign o_entry_total  = r_tot;

endmodule

// ===== hdl/indirect_jump_target_scanner.sv =====
// Per byte: accepted when start && !busy; busy through the CALC, CHECK and WRAP states after
//   acceptance, plus a DEDUP table scan when the window matches and passes the checks.
// Last byte: after that, one result per table scan, ascending;
//   an empty list gives one result, registered from the wrap step. Results cannot be stalled.
// Throughput set by the single-read-port target table walked one entry per cycle.
// Reset (i_rst_n low, synchronous): config to defaults, scan state and count cleared.
module indirect_jump_target_scanner #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cfg_we,
    input  logic [ijts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ijts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [7:0]                      i_code_byte,
    input  logic                            i_last_byte,
    output logic                            o_strobe,
    output logic [31:0]                     o_target_value,
    output logic                            o_entry_valid,
    output logic                            o_final_entry,
    output logic [5:0]                      o_entry_total
);
    import ijts_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ijts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    ijts_dp #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_code_byte    (i_code_byte),
        .i_last_byte    (i_last_byte),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_strobe       (o_strobe),
        .o_target_value (o_target_value),
        .o_entry_valid  (o_entry_valid),
        .o_final_entry  (o_final_entry),
        .o_entry_total  (o_entry_total)
    );

endmodule

// ===== hdl/ijts_chk.sv =====
module ijts_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_strobe,
    input logic       o_entry_valid,
    input logic       o_final_entry,
    input logic [5:0] o_entry_total
);

    // a result beat always comes out of a busy cycle
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result beat without preceding busy cycle");

    // a byte is never answered in the cycle right after acceptance
    a_no_beat_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_strobe)
        else $error("result beat right after byte acceptance");

    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_entry_valid) |-> (o_final_entry && (o_entry_total == 6'd0)))
        else $error("malformed empty-list beat");

    // list ends together with the scan; more entries keep the block busy
    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_final_entry) |-> !busy)
        else $error("busy after final beat");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_final_entry) |-> (busy && o_entry_valid && (o_entry_total != 6'd0)))
        else $error("bad non-final beat");

endmodule

bind indirect_jump_target_scanner ijts_chk u_chk (.*);

// ===== tb/tb_indirect_jump_target_scanner.sv =====
module tb_indirect_jump_target_scanner;
    timeunit 1ns;
    timeprecision 1ps;

    import ijts_pkg::*;

    localparam int TBL_DEPTH     = 32;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_BYTES   = 66;

    typedef struct packed {
        logic [31:0] value;
        logic        valid;
        logic        fin;
        logic [5:0]  total;
    } t_jump_entry;

    localparam t_jump_entry EMPTY_LIST = {32'd0, 1'b0, 1'b1, 6'd0};

    typedef struct packed {
        logic        is_cfg;
        t_cfg_idx    idx;
        logic [31:0] data;
        logic [7:0]  code;
        logic        lst;
        logic        typed;
        t_jump_entry want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic        busy;
    logic        i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic [7:0]  i_code_byte    = 8'd0;
    logic        i_last_byte    = 1'b0;
    logic        o_strobe;
    logic [31:0] o_target_value;
    logic        o_entry_valid;
    logic        o_final_entry;
    logic [5:0]  o_entry_total;

    indirect_jump_target_scanner #(.TABLE_DEPTH(TBL_DEPTH)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_code_byte    (i_code_byte),
        .i_last_byte    (i_last_byte),
        .o_strobe       (o_strobe),
        .o_target_value (o_target_value),
        .o_entry_valid  (o_entry_valid),
        .o_final_entry  (o_final_entry),
        .o_entry_total  (o_entry_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // scanner model: settings
    logic        m_pe32  = 1'b0;
    logic [31:0] m_rva   = 32'd0;
    logic [31:0] m_base  = 32'd0;
    logic [31:0] m_size  = 32'd0;
    logic [5:0]  m_maxt  = MAX_T_RST;

    // scanner model: scan state
    logic [7:0]  hist [0:4];
    int          hist_fill;
    logic [31:0] scan_pos;
    logic [31:0] target_tab [0:TBL_DEPTH-1];
    int          n_stored;

    t_jump_entry target_list_q [$];
    t_jump_entry expected_q [$];
    logic [7:0]  scan_bytes [$];
    t_stim_row   plan [$];

    int idle_pct         = 16;
    int errors           = 0;
    int cycle_count      = 0;
    int bytes_sent       = 0;
    int scans_sent       = 0;
    int results_expected = 0;
    int results_checked  = 0;
    int settings_loaded  = 0;

    t_jump_entry got_entry, want_entry;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, expected_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            got_entry = {o_target_value, o_entry_valid, o_final_entry, o_entry_total};
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result value=%h valid=%b final=%b total=%0d",
                         $time, got_entry.value, got_entry.valid, got_entry.fin,
                         got_entry.total);
            end else begin
                want_entry = expected_q.pop_front();
                results_checked++;
                if (got_entry !== want_entry) begin
                    errors++;
                    $display("%0t: expected value=%h valid=%b final=%b total=%0d, got value=%h valid=%b final=%b total=%0d",
                             $time, want_entry.value, want_entry.valid, want_entry.fin,
                             want_entry.total, got_entry.value, got_entry.valid,
                             got_entry.fin, got_entry.total);
                end
            end
        end
    end

    task automatic clear_scan();
        for (int i = 0; i < 5; i++) hist[i] = 8'd0;
        for (int i = 0; i < TBL_DEPTH; i++) target_tab[i] = 32'd0;
        hist_fill = 0;
        scan_pos  = 32'd0;
        n_stored  = 0;
    endtask

    // Advance the model by one byte; on the last byte fill target_list_q.
    task automatic step_scanner(input logic [7:0] b, input logic lst);
        logic [31:0] raw, tgt, k, key;
        logic [31:0] srt [0:TBL_DEPTH-1];
        longint      sum;
        bit          keep, dup;
        int          lim, j;
        target_list_q.delete();
        if (hist_fill >= 5 && hist[0] == OPC_ESC &&
            (hist[1] == MODRM_JMP || (m_pe32 && hist[1] == MODRM_CALL))) begin
            raw = {b, hist[4], hist[3], hist[2]};
            k   = scan_pos - 32'd5;
            if (m_pe32) begin
                tgt  = raw - m_base;
                keep = ({32'd0, tgt} + 64'd4) <= {32'd0, m_size};
            end else begin
                // RIP-relative: computed exactly, then range checked
                sum  = longint'(m_rva) + longint'(k) + 64'sd6 + longint'($signed(raw));
                keep = sum >= 0 && sum <= 64'sh0ffffffff && sum + 8 <= longint'(m_size);
                tgt  = sum[31:0];
            end
            if (keep) begin
                dup = 1'b0;
                for (int i = 0; i < n_stored; i++)
                    if (target_tab[i] == tgt) dup = 1'b1;
                lim = (m_maxt > TBL_DEPTH) ? TBL_DEPTH : int'(m_maxt);
                if (!dup && n_stored < lim) begin
                    target_tab[n_stored] = tgt;
                    n_stored++;
                end
            end
        end
        for (int i = 0; i < 4; i++) hist[i] = hist[i+1];
        hist[4] = b;
        if (hist_fill < 5) hist_fill++;
        scan_pos = scan_pos + 32'd1;
        if (lst) begin
            for (int i = 0; i < n_stored; i++) begin
                key = target_tab[i];
                j = i;
                while (j > 0 && srt[j-1] > key) begin
                    srt[j] = srt[j-1];
                    j--;
                end
                srt[j] = key;
            end
            if (n_stored == 0)
                target_list_q.push_back(EMPTY_LIST);
            for (int i = 0; i < n_stored; i++)
                target_list_q.push_back({srt[i], 1'b1, (i + 1 == n_stored), 6'(n_stored)});
            clear_scan();
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic lst, input logic typed,
                             input t_jump_entry want);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_code_byte <= b;
        i_last_byte <= lst;
        do @(posedge i_clk); while (busy);
        bytes_sent++;
        step_scanner(b, lst);
        if (typed) begin
            expected_q.push_back(want);
            results_expected++;
        end else begin
            foreach (target_list_q[i]) expected_q.push_back(target_list_q[i]);
            results_expected += target_list_q.size();
        end
        if (lst) scans_sent++;
    endtask

    // all results drained and the block quiet
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_PE32_MODE:   m_pe32 = val[0];
            CFG_SECTION_RVA: m_rva  = val;
            CFG_MAPPED_BASE: m_base = val;
            CFG_IMAGE_SIZE:  m_size = val;
            CFG_MAX_TARGETS: m_maxt = val[5:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic pe, input logic [31:0] rva,
                                 input logic [31:0] base, input logic [31:0] size,
                                 input logic [5:0] maxt);
        wait_idle();
        write_reg(CFG_PE32_MODE, {31'd0, pe});
        write_reg(CFG_SECTION_RVA, rva);
        write_reg(CFG_MAPPED_BASE, base);
        write_reg(CFG_IMAGE_SIZE, size);
        write_reg(CFG_MAX_TARGETS, {26'd0, maxt});
        settings_loaded++;
    endtask

    function automatic logic [31:0] pick_addr();
        case ($urandom_range(3))
            0:       return 32'd0;
            1:       return 32'hffffffff;
            2:       return $urandom_range(0, 32'h000fffff);
            default: return $urandom;
        endcase
    endfunction

    task automatic load_random_settings();
        logic [31:0] size;
        logic [5:0]  maxt;
        case ($urandom_range(9))
            0:          size = 32'd0;
            1, 2, 3, 4: size = 32'hffffffff;
            5:          size = $urandom_range(0, 12);
            default:    size = $urandom_range(32'h100, 32'h100000);
        endcase
        case ($urandom_range(9))
            0:       maxt = 6'd0;
            1:       maxt = 6'd1;
            2, 3:    maxt = 6'd32;
            4, 5:    maxt = 6'd63;
            default: maxt = 6'($urandom_range(2, 40));
        endcase
        load_settings(1'($urandom_range(1)), pick_addr(), pick_addr(), size, maxt);
    endtask

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(7))
            0:       return OPC_ESC;
            1:       return MODRM_JMP;
            2:       return MODRM_CALL;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [31:0] pick_target(input logic [31:0] pool [0:3]);
        logic [31:0] esize;
        esize = m_pe32 ? 32'(ESIZE_32) : 32'(ESIZE_64);
        if (m_size < esize || $urandom_range(9) == 0)
            return $urandom;
        case ($urandom_range(5))
            0:       return m_size - esize + 32'd1;   // one past the image end
            1, 2:    return $urandom_range(0, m_size - esize);
            default: return pool[$urandom_range(3)];
        endcase
    endfunction

    // ff 25/15 + disp32 windows aimed at chosen targets, with noise between
    task automatic build_jump_scan();
        logic [31:0] pool [0:3];
        logic [31:0] t, raw, k, esize;
        int          npat;
        esize = m_pe32 ? 32'(ESIZE_32) : 32'(ESIZE_64);
        for (int i = 0; i < 4; i++)
            pool[i] = (m_size >= esize) ? $urandom_range(0, m_size - esize) : $urandom;
        if (m_size >= esize) pool[0] = m_size - esize;
        npat = $urandom_range(0, 6);
        for (int p = 0; p < npat; p++) begin
            repeat ($urandom_range(0, 3)) scan_bytes.push_back(noise_byte());
            k   = 32'(scan_bytes.size());
            t   = pick_target(pool);
            raw = m_pe32 ? t + m_base : t - m_rva - k - 32'(WIN_LEN);
            scan_bytes.push_back(OPC_ESC);
            if (m_pe32)
                scan_bytes.push_back($urandom_range(1) ? MODRM_JMP : MODRM_CALL);
            else
                scan_bytes.push_back($urandom_range(7) == 0 ? MODRM_CALL : MODRM_JMP);
            scan_bytes.push_back(raw[7:0]);
            scan_bytes.push_back(raw[15:8]);
            scan_bytes.push_back(raw[23:16]);
            scan_bytes.push_back(raw[31:24]);
        end
        // often the final window ends right on the last byte
        if ($urandom_range(2) != 0 || scan_bytes.size() == 0)
            repeat ($urandom_range(1, 4)) scan_bytes.push_back(noise_byte());
    endtask

    task automatic build_dense_scan(input int pairs);
        repeat (pairs) begin
            scan_bytes.push_back(OPC_ESC);
            scan_bytes.push_back(MODRM_JMP);
        end
        repeat ($urandom_range(0, 2)) scan_bytes.push_back(noise_byte());
    endtask

    task automatic send_scan();
        foreach (scan_bytes[i])
            push_byte(scan_bytes[i], i == scan_bytes.size() - 1, 1'b0, EMPTY_LIST);
        scan_bytes.delete();
    endtask

    function automatic t_stim_row byte_row(input logic [7:0] code);
        return {1'b0, CFG_PE32_MODE, 32'd0, code, 1'b0, 1'b0, EMPTY_LIST};
    endfunction

    function automatic t_stim_row last_row(input logic [7:0] code, input t_jump_entry want);
        return {1'b0, CFG_PE32_MODE, 32'd0, code, 1'b1, 1'b1, want};
    endfunction

    function automatic t_stim_row cfg_row(input t_cfg_idx idx, input logic [31:0] data);
        return {1'b1, idx, data, 8'd0, 1'b0, 1'b0, EMPTY_LIST};
    endfunction

    initial begin
        int pct [0:2];
        int phase_bytes, pick;
        bit first;
        pct[0] = 16;
        pct[1] = 69;
        pct[2] = 0;
        clear_scan();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one-byte section after reset: empty list
        plan.push_back(last_row(8'h00, EMPTY_LIST));
        // image size still zero, so the match is rejected
        plan.push_back(byte_row(8'hff));
        plan.push_back(byte_row(8'h25));
        plan.push_back(byte_row(8'h00));
        plan.push_back(byte_row(8'h00));
        plan.push_back(byte_row(8'h00));
        plan.push_back(last_row(8'h00, EMPTY_LIST));
        // displacement -1 from offset 0: target 5
        plan.push_back(cfg_row(CFG_IMAGE_SIZE, 32'hffffffff));
        plan.push_back(byte_row(8'hff));
        plan.push_back(byte_row(8'h25));
        plan.push_back(byte_row(8'hff));
        plan.push_back(byte_row(8'hff));
        plan.push_back(byte_row(8'hff));
        plan.push_back(last_row(8'hff, {32'd5, 1'b1, 1'b1, 6'd1}));
        // RIP-relative target above 32 bits is dropped
        plan.push_back(cfg_row(CFG_SECTION_RVA, 32'hfffffff0));
        plan.push_back(byte_row(8'hff));
        plan.push_back(byte_row(8'h25));
        plan.push_back(byte_row(8'h10));
        plan.push_back(byte_row(8'h00));
        plan.push_back(byte_row(8'h00));
        plan.push_back(last_row(8'h00, EMPTY_LIST));
        // absolute call form minus mapped base
        plan.push_back(cfg_row(CFG_PE32_MODE, 32'd1));
        plan.push_back(cfg_row(CFG_MAPPED_BASE, 32'h00400000));
        plan.push_back(cfg_row(CFG_MAX_TARGETS, 32'd63));
        plan.push_back(byte_row(8'hff));
        plan.push_back(byte_row(8'h15));
        plan.push_back(byte_row(8'h00));
        plan.push_back(byte_row(8'h10));
        plan.push_back(byte_row(8'h40));
        plan.push_back(last_row(8'h00, {32'h1000, 1'b1, 1'b1, 6'd1}));

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                wait_idle();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                push_byte(plan[i].code, plan[i].lst, plan[i].typed, plan[i].want);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct    = pct[ph];
            phase_bytes = bytes_sent;
            first       = 1'b1;
            while (bytes_sent - phase_bytes < PHASE_BYTES) begin
                if (ph == 2 && first) begin
                    // enough distinct targets to overflow the table
                    load_settings(1'b0, $urandom_range(0, 32'hffff), $urandom,
                                  32'hffffffff, 6'd63);
                    build_dense_scan(38);
                end else begin
                    if (first || $urandom_range(1) == 0) load_random_settings();
                    pick = $urandom_range(9);
                    if (pick == 0)
                        build_dense_scan($urandom_range(8, 24));
                    else if (pick <= 2)
                        repeat ($urandom_range(1, 20)) scan_bytes.push_back(noise_byte());
                    else
                        build_jump_scan();
                end
                send_scan();
                first = 1'b0;
            end
        end

        wait_idle();
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);

        $display("Scanned %0d sections (%0d code bytes) over %0d register settings",
                 scans_sent, bytes_sent, settings_loaded);
        $display("Checked %0d target list entries, %0d mismatches", results_checked, errors);
        if (errors == 0 && expected_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
